// ===== hw/rtl/lpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared constants, types and helpers of the look-ahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

	localparam int DATA_W          = 24;
	localparam int WINDOW_LOG2_DEF = 8;
	localparam int CHANNELS_DEF    = 2;
	localparam int DIV_DVD_W       = 48;
	localparam int DIV_Q_W         = 24;

	localparam logic [DATA_W-1:0] ONE_Q23   = 24'h800000;
	localparam logic [DATA_W-1:0] THR_RESET = 24'd8387769;

	// floor smoothing: (9*floor + new + 5) / 10 by reciprocal, exact below 2^30
	localparam int                 LPD_W    = 27;
	localparam int                 RCP10_W  = 28;
	localparam logic [RCP10_W-1:0] RCP10    = 28'd214748365;
	localparam int                 RCP10_SH = 31;

	// gain recovery: remainder term / 1000 by reciprocal, exact below 2^24
	localparam int                 RCP1K_W  = 25;
	localparam logic [RCP1K_W-1:0] RCP1K    = 25'd17179870;
	localparam int                 RCP1K_SH = 34;
	localparam logic [DATA_W-1:0]  GAIN_RND = 24'd500;

	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_RING = 16'b0000_0000_0000_0010,
		S_CLR  = 16'b0000_0000_0000_0100,
		S_TWR  = 16'b0000_0000_0000_1000,
		S_TMX  = 16'b0000_0000_0001_0000,
		S_FLD  = 16'b0000_0000_0010_0000,
		S_FLW  = 16'b0000_0000_0100_0000,
		S_LPD  = 16'b0000_0000_1000_0000,
		S_LPW  = 16'b0000_0001_0000_0000,
		S_GD   = 16'b0000_0010_0000_0000,
		S_GW   = 16'b0000_0100_0000_0000,
		S_MUL1 = 16'b0000_1000_0000_0000,
		S_LIM  = 16'b0001_0000_0000_0000,
		S_LIMW = 16'b0010_0000_0000_0000,
		S_MUL2 = 16'b0100_0000_0000_0000,
		S_FIN  = 16'b1000_0000_0000_0000
	} state_t;

	// magnitude of a two's complement word, most negative gives 2^23
	function automatic word_t mag24(input word_t raw);
		mag24 = raw[DATA_W-1] ? (~raw + 24'd1) : raw;
	endfunction

endpackage

// ===== hw/rtl/lpl_ram.sv =====
// ----------------------------------------------------------------------------
// lpl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lpl_div.sv =====
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module lpl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lpl_pkg::DIV_DVD_W-1:0]   dividend,
	input  logic [lpl_pkg::DATA_W-1:0]      divisor,
	output logic                            busy,
	output logic                            done,
	output logic [lpl_pkg::DIV_Q_W-1:0]     quotient
);
	import lpl_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic [DATA_W-1:0]  rem_q;
	logic [DIV_Q_W-1:0] dvd_q;
	logic [DATA_W-1:0]  dsr_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DATA_W:0]    trial;
	logic               ge;

	assign trial = {rem_q, dvd_q[DIV_Q_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(DIV_Q_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIV_DVD_W-1 -: DATA_W];
			dvd_q <= dividend[DIV_Q_W-1:0];
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DATA_W'(trial - {1'b0, dsr_q}) : trial[DATA_W-1:0];
			dvd_q <= {dvd_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/lookahead_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// lookahead_peak_limiter
// Per-channel look-ahead limiter: delay ring and sliding max tree in RAM,
// gain smoothing and hard clamp through one shared serial divider.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | dir
//  ---------+-----------------------------------------+-----
//  input    | in_valid, in_stall, sample_in, channel  | in
//  output   | out_valid, out_stall, sample_out,       | out
//           | channel_out, limiting                   |
//  config   | cfg_we, cfg_data                        | in
//
// One request at a time, paced by the tree walk and the bit-serial divider
// (up to two divides per request; the divisions by ten and a thousand
// are reciprocal multiplies).
// A request that arms a channel first clears that channel's tree in RAM. No
// clearing after reset; the ring tracks a per-channel wrap flag. A finished
// result waits in the output register while the next request is taken; the
// sequencer holds only if that register is still full when it finishes.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter #(
	parameter int WINDOW_LOG2 = lpl_pkg::WINDOW_LOG2_DEF,
	parameter int CHANNELS    = lpl_pkg::CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lpl_pkg::DATA_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [lpl_pkg::DATA_W-1:0] sample_in,
	input  logic                       channel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lpl_pkg::DATA_W-1:0] sample_out,
	output logic                       channel_out,
	output logic                       limiting
);
	import lpl_pkg::*;

	localparam int WIN    = 1 << WINDOW_LOG2;
	localparam int TREE   = 2 * WIN - 2;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NODE_W = WINDOW_LOG2 + 1;
	localparam int LVL_W  = $clog2(WINDOW_LOG2 + 1);
	localparam int RING_A = CH_W + WINDOW_LOG2;
	localparam int TREE_A = CH_W + NODE_W;

	state_t state_q;

	word_t                  thr_q;
	word_t                  mag_q, raw_q, v_q, fl_q, lp_q, g_q, gy_q;
	logic [LPD_W-1:0]       lpd_q;
	logic [CH_W-1:0]        ch_q, ch_in;
	logic [WINDOW_LOG2-1:0] pos_q, npos_q, off_q;
	logic [NODE_W-1:0]      clr_q;
	logic [LVL_W-1:0]       lvl_q;
	logic                   armed_w_q;
	logic [2*DATA_W-1:0]    prod_q;

	word_t                  gain_r   [CHANNELS];
	word_t                  floor_r  [CHANNELS];
	logic [WINDOW_LOG2-1:0] rpos_r   [CHANNELS];
	logic                   armed_r  [CHANNELS];
	logic                   wrap_r   [CHANNELS];

	logic                   out_valid_q;
	word_t                  sample_out_q;
	logic                   channel_out_q;
	logic                   limiting_q;

	logic                   accept;
	logic                   out_free;

	// ring ram
	logic                   ring_we;
	logic [RING_A-1:0]      ring_waddr, ring_raddr;
	word_t                  ring_rdata;

	// tree ram
	logic                   tree_we;
	logic [TREE_A-1:0]      tree_waddr, tree_raddr;
	word_t                  tree_wdata, tree_rdata;
	logic [NODE_W:0]        base_full;
	logic [NODE_W-1:0]      base, node, sib;

	// divider
	logic                   div_start, div_busy, div_done;
	logic [DIV_DVD_W-1:0]   div_dvd;
	word_t                  div_dsr;
	logic [DIV_Q_W-1:0]     div_q;

	// reciprocal multiplies for the constant divisions
	logic [LPD_W+RCP10_W-1:0]  lp_prod;
	logic [DATA_W+RCP1K_W-1:0] gy_prod;
	word_t                     lp_new, g_new;

	word_t                  o;
	logic [DIV_DVD_W-1:0]   lim;
	logic                   hit, armed_fin;
	word_t                  m, vmax;

	assign ch_in    = (CHANNELS == 1) ? '0 : CH_W'(channel);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign o   = mag24(raw_q);
	assign lim = DIV_DVD_W'({thr_q, 22'b0});
	assign hit = {mag_q, 1'b0} > {1'b0, thr_q};
	assign armed_fin = armed_w_q && ({v_q, 1'b0} > {1'b0, thr_q});
	assign vmax = (tree_rdata > v_q) ? tree_rdata : v_q;
	assign m    = prod_q[2*DATA_W-2 -: DATA_W];

	// 999*g + 2^23 + 500 = 1000*g + (2^23 + 500 - g)
	assign lp_prod = (LPD_W+RCP10_W)'(lpd_q) * (LPD_W+RCP10_W)'(RCP10);
	assign lp_new  = lp_prod[RCP10_SH +: DATA_W];
	assign gy_prod = (DATA_W+RCP1K_W)'(gy_q) * (DATA_W+RCP1K_W)'(RCP1K);
	assign g_new   = gain_r[ch_q] + DATA_W'(gy_prod[DATA_W+RCP1K_W-1:RCP1K_SH]);

	assign base_full = (NODE_W+1)'(2 * WIN) - ((NODE_W+1)'(2) << lvl_q);
	assign base      = base_full[NODE_W-1:0];
	assign node      = base + NODE_W'(off_q);
	assign sib       = base + NODE_W'(off_q ^ WINDOW_LOG2'(1));

	assign ring_we    = accept;
	assign ring_waddr = {ch_in, rpos_r[ch_in]};
	assign ring_raddr = {ch_in, rpos_r[ch_in] + WINDOW_LOG2'(1)};

	always_comb begin
		tree_we    = 1'b0;
		tree_waddr = {ch_q, node};
		tree_wdata = v_q;
		tree_raddr = {ch_q, sib};
		if (state_q == S_CLR) begin
			tree_we    = 1'b1;
			tree_waddr = {ch_q, clr_q};
			tree_wdata = '0;
		end else if (state_q == S_TWR) begin
			tree_we = 1'b1;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = lim;
		div_dsr   = v_q;
		unique case (state_q)
			S_FLD: begin
				div_start = armed_fin;
			end
			S_LIM: begin
				div_start = (prod_q > lim);
				div_dsr   = o;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lpl_ram #(.WIDTH(DATA_W), .DEPTH(1 << RING_A)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (sample_in),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	lpl_ram #(.WIDTH(DATA_W), .DEPTH(1 << TREE_A)) u_tree (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.raddr (tree_raddr),
		.rdata (tree_rdata)
	);

	lpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				gain_r[i]  <= ONE_Q23;
				floor_r[i] <= ONE_Q23;
				rpos_r[i]  <= '0;
				armed_r[i] <= 1'b0;
				wrap_r[i]  <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				thr_q <= (cfg_data > ONE_Q23) ? ONE_Q23 : cfg_data;
			end
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RING;
					end
				end
				S_RING: begin
					rpos_r[ch_q] <= npos_q;
					if (npos_q == '0) begin
						wrap_r[ch_q] <= 1'b1;
					end
					if (hit && !armed_r[ch_q]) begin
						state_q <= S_CLR;
					end else if (armed_r[ch_q]) begin
						state_q <= S_TWR;
					end else begin
						state_q <= S_FLD;
					end
				end
				S_CLR: begin
					if (clr_q == NODE_W'(TREE - 1)) begin
						state_q <= S_TWR;
					end
				end
				S_TWR: begin
					state_q <= S_TMX;
				end
				S_TMX: begin
					state_q <= (lvl_q == LVL_W'(1)) ? S_FLD : S_TWR;
				end
				S_FLD: begin
					armed_r[ch_q] <= armed_fin;
					state_q       <= armed_fin ? S_FLW : S_LPD;
				end
				S_FLW: begin
					if (div_done) begin
						state_q <= S_LPD;
					end
				end
				S_LPD: begin
					state_q <= S_LPW;
				end
				S_LPW: begin
					floor_r[ch_q] <= lp_new;
					state_q       <= S_GD;
				end
				S_GD: begin
					state_q <= S_GW;
				end
				S_GW: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_LIM;
				end
				S_LIM: begin
					state_q <= div_start ? S_LIMW : S_FIN;
				end
				S_LIMW: begin
					if (div_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						gain_r[ch_q] <= g_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mag_q  <= mag24(sample_in);
				ch_q   <= ch_in;
				pos_q  <= rpos_r[ch_in];
				npos_q <= rpos_r[ch_in] + WINDOW_LOG2'(1);
			end
			S_RING: begin
				// entry not yet written since reset reads as zero
				raw_q     <= (wrap_r[ch_q] || npos_q == '0) ? ring_rdata : '0;
				armed_w_q <= armed_r[ch_q] || hit;
				clr_q     <= '0;
				lvl_q     <= LVL_W'(WINDOW_LOG2);
				off_q     <= pos_q;
				v_q       <= mag_q;
			end
			S_CLR: begin
				clr_q <= clr_q + NODE_W'(1);
			end
			S_TMX: begin
				v_q   <= vmax;
				off_q <= off_q >> 1;
				lvl_q <= lvl_q - LVL_W'(1);
			end
			S_FLD: begin
				armed_w_q <= armed_fin;
				fl_q      <= thr_q;
			end
			S_FLW: begin
				if (div_done) begin
					fl_q <= div_q;
				end
			end
			S_LPD: begin
				lpd_q <= LPD_W'(floor_r[ch_q]) * LPD_W'(9) + LPD_W'(fl_q) + LPD_W'(5);
			end
			S_LPW: begin
				lp_q <= lp_new;
			end
			S_GD: begin
				gy_q <= ONE_Q23 + GAIN_RND - gain_r[ch_q];
			end
			S_GW: begin
				g_q <= (lp_q < g_new) ? lp_q : g_new;
			end
			S_MUL1, S_MUL2: begin
				prod_q <= o * g_q;
			end
			S_LIMW: begin
				if (div_done) begin
					g_q <= div_q;
				end
			end
			S_FIN: begin
				if (out_free) begin
					sample_out_q  <= raw_q[DATA_W-1] ? (~m + 24'd1) : m;
					channel_out_q <= ch_q[0];
					limiting_q    <= armed_w_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;
	assign limiting    = limiting_q;

	// the result never exceeds the threshold
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({mag24(sample_out), 1'b0} <= {1'b0, thr_q}))
		else $error("output above threshold");

	// divider is idle whenever a new request can be taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_busy)
		else $error("divider busy while idle");

	// the stored gain never exceeds one
	a_gain_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (g_q <= ONE_Q23))
		else $error("gain above one");

	// a channel only leaves the tree walk with its armed flag settled
	a_fld_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLD) |=> (armed_r[ch_q] == armed_w_q))
		else $error("armed flag not stored");

endmodule
